### hw/rtl/cipc_pkg.sv
// Package for the case-insensitive pattern counter.
// Holds the payload structs, queue status, register indexes and byte folding.
// No dependencies; every RTL file of the block uses it by scoped names.
package cipc_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int PAT_LEN_W   = 5;
  localparam int PAT_BYTES   = 16;
  localparam int COUNT_W     = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } in_req_t;

  typedef struct packed {
    logic [7:0]         lowered_char;
    logic               match_end;
    logic               line_had_match;
    logic [COUNT_W-1:0] total_matches;
    logic [COUNT_W-1:0] matching_lines;
  } out_req_t;

  // Classified item passed from the front end to the back end
  typedef struct packed {
    logic [7:0] lowered;
    logic       eol;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

### hw/rtl/cipc_front.sv
// Front end of the case-insensitive pattern counter: accepts requests,
// folds the byte and classifies the item, then pushes it into the queue.
// Depends on cipc_pkg.
module cipc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  cipc_pkg::in_req_t in_data,
  input  cipc_pkg::qstat_t qstat,
  output logic             push,
  output cipc_pkg::item_t  push_item
);

  logic            fr_valid;
  cipc_pkg::item_t fr_item;

  assign push      = fr_valid && !qstat.full;
  assign in_stall  = fr_valid && qstat.full;
  assign push_item = fr_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      fr_valid <= 1'b1;
    end else if (push) begin
      fr_valid <= 1'b0;
    end
  end

  // End of line carries no character: send zero in its place
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      fr_item.eol     <= in_data.end_of_line;
      fr_item.lowered <= in_data.end_of_line ? 8'h00
                                             : cipc_pkg::fold_byte(in_data.char_code);
    end
  end

endmodule

### hw/rtl/cipc_queue.sv
// Two-entry queue between the front and back ends of the pattern counter.
// Registered storage, head read at the read pointer. Depends on cipc_pkg.
module cipc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cipc_pkg::item_t  push_item,
  input  logic             pop,
  output cipc_pkg::item_t  head_item,
  output cipc_pkg::qstat_t qstat
);

  localparam int PTR_W = $clog2(cipc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(cipc_pkg::QUEUE_DEPTH + 1);

  cipc_pkg::item_t  mem [cipc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head_item   = mem[rd_ptr];
  assign qstat.full  = (count == CNT_W'(cipc_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(cipc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(cipc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/cipc_back.sv
// Back end of the pattern counter: character window, parallel compare with
// the folded pattern, fill count, saturating counters and the output register.
// Depends on cipc_pkg.
module cipc_back #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [cipc_pkg::CFG_DATA_W-1:0]    pattern_low,
  input  logic [cipc_pkg::CFG_DATA_W-1:0]    pattern_high,
  input  logic [cipc_pkg::PAT_LEN_W-1:0]     pattern_length,
  input  cipc_pkg::item_t                    head_item,
  input  cipc_pkg::qstat_t                   qstat,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output cipc_pkg::out_req_t                 out_data
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int LW     = cipc_pkg::PAT_LEN_W;
  localparam int CW     = cipc_pkg::COUNT_W;

  logic [7:0]        window [MAX_PATTERN];
  logic [FILL_W-1:0] fill;
  logic              line_matched;
  logic [CW-1:0]     match_count;
  logic [CW-1:0]     line_count;

  logic [7:0]        window_next [MAX_PATTERN];
  logic [7:0]        pat_fold [cipc_pkg::PAT_BYTES];
  logic [127:0]      pat_all;
  logic [LW-1:0]     len;
  logic [LW-1:0]     pidx;
  logic [FILL_W-1:0] fill_inc;
  logic              all_eq;
  logic              hit;
  logic              line_hit;
  logic [CW-1:0]     match_count_next;
  logic [CW-1:0]     line_count_next;

  assign pop = !qstat.empty && (!out_valid || !out_stall);

  always_comb begin
    pat_all = {pattern_high, pattern_low};
    for (int k = 0; k < cipc_pkg::PAT_BYTES; k++) begin
      pat_fold[k] = cipc_pkg::fold_byte(pat_all[8*k +: 8]);
    end
    len = (pattern_length > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : pattern_length;

    // Shift the new byte in at the newest end
    window_next[0] = head_item.lowered;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      window_next[j] = window[j-1];
    end
    fill_inc = (fill < FILL_W'(MAX_PATTERN)) ? fill + FILL_W'(1) : fill;

    // Window slot j holds the byte that must equal pattern byte len-1-j
    all_eq = 1'b1;
    pidx   = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pidx = len - LW'(1) - LW'(j);
      if (LW'(j) < len && window_next[j] != pat_fold[pidx[3:0]]) begin
        all_eq = 1'b0;
      end
    end
    hit = !head_item.eol && (len != '0) && ((LW + 1)'(fill_inc) >= (LW + 1)'(len)) && all_eq;
    line_hit = head_item.eol && line_matched;

    match_count_next = (hit && match_count != cipc_pkg::COUNT_MAX)
                       ? match_count + CW'(1) : match_count;
    line_count_next  = (line_hit && line_count != cipc_pkg::COUNT_MAX)
                       ? line_count + CW'(1) : line_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      fill         <= '0;
      line_matched <= 1'b0;
      match_count  <= '0;
      line_count   <= '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        window[j] <= 8'h00;
      end
    end else if (pop) begin
      out_valid   <= 1'b1;
      match_count <= match_count_next;
      line_count  <= line_count_next;
      if (head_item.eol) begin
        fill         <= '0;
        line_matched <= 1'b0;
      end else begin
        window <= window_next;
        fill   <= hit ? '0 : fill_inc;
        if (hit) begin
          line_matched <= 1'b1;
        end
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.lowered_char   <= head_item.lowered;
      out_data.match_end      <= hit;
      out_data.line_had_match <= line_hit;
      out_data.total_matches  <= match_count_next;
      out_data.matching_lines <= line_count_next;
    end
  end

endmodule

### hw/rtl/case_insensitive_pattern_counter.sv
// Top level of the case-insensitive pattern counter: configuration registers,
// front end, queue and back end. Depends on cipc_pkg, cipc_front, cipc_queue
// and cipc_back.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall   cipc_pkg::in_req_t  (char, end of line)
//   out      source     out_valid / out_stall cipc_pkg::out_req_t (folded char, flags, counts)
//   cfg      sink       cfg_write             cfg_index, cfg_data
//
// One item per cycle sustained while out_stall stays low; the window compare
// over all pattern bytes is combinational in the back end.
// An accepted item passes the front register, a queue entry and the output register.
// Synchronous reset clears handshake state, window, counters and sets the
// pattern length to one.
// A stalled output fills the two-entry queue, then the front register, then
// raises in_stall.
module case_insensitive_pattern_counter #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cipc_pkg::in_req_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cipc_pkg::out_req_t              out_data,
  input  logic                            cfg_write,
  input  logic [cipc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cipc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [cipc_pkg::CFG_DATA_W-1:0] pattern_low;
  logic [cipc_pkg::CFG_DATA_W-1:0] pattern_high;
  logic [cipc_pkg::PAT_LEN_W-1:0]  pattern_length;

  logic             push;
  logic             pop;
  cipc_pkg::item_t  push_item;
  cipc_pkg::item_t  head_item;
  cipc_pkg::qstat_t qstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= cipc_pkg::PAT_LEN_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        cipc_pkg::REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        cipc_pkg::REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        cipc_pkg::REG_PATTERN_LEN:  pattern_length <= cfg_data[cipc_pkg::PAT_LEN_W-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  cipc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  cipc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .qstat     (qstat)
  );

  cipc_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .pattern_low    (pattern_low),
    .pattern_high   (pattern_high),
    .pattern_length (pattern_length),
    .head_item      (head_item),
    .qstat          (qstat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule

### hw/rtl/cipc_checker.sv
// Port-level checker for the case-insensitive pattern counter, bound to the
// top level. Depends on cipc_pkg.
module cipc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input cipc_pkg::out_req_t              out_data
);

  // A stalled request holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output request changed while stalled");

  // A line counts only if it holds a match, saturation keeps the order
  a_lines_le_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.matching_lines <= out_data.total_matches)
    else $error("matching lines exceed total matches");

  // A line-match result has no character, no match end, nonzero line count
  a_eol_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.line_had_match |->
      !out_data.match_end && out_data.lowered_char == 8'h00 &&
      out_data.matching_lines != '0)
    else $error("malformed end-of-line result");

  // A match end has been counted
  a_match_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.match_end |-> out_data.total_matches != '0)
    else $error("match end without count");

  // Nothing leaves right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind case_insensitive_pattern_counter cipc_checker u_cipc_checker (.*);

### dv/testbench.sv
// Self-checking testbench for case_insensitive_pattern_counter (uses cipc_pkg).
// Drives character and end-of-line requests, rewrites the pattern registers between
// phases and checks each result against a local predictor or a typed-in one.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cipc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic {ROW_WRITE, ROW_REQ} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] value;
    in_req_t              req;
    logic                 fixed;
    out_req_t             want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_req_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_req_t              out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;

  // Predictor state: configuration and the block's own registers
  logic [PAT_BYTES-1:0][7:0] pattern_regs = '0;
  logic [PAT_LEN_W-1:0]      pattern_len = 5'd1;
  logic [PAT_BYTES-1:0][7:0] window = '0;
  int unsigned               fill_count = 0;
  logic                      line_hit = 1'b0;
  logic [COUNT_W-1:0]        match_total = '0;
  logic [COUNT_W-1:0]        lines_total = '0;

  out_req_t awaited_results [$];
  row_t     directed_rows [$];

  case_insensitive_pattern_counter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? 8'(c + 8'h20) : c;
  endfunction

  // Give a letter a random case; other bytes pass through folded
  function automatic logic [7:0] mixed_case(input logic [7:0] c);
    logic [7:0] f;
    f = to_lower(c);
    if (f >= 8'h61 && f <= 8'h7A && $urandom_range(1) == 1) begin
      f = 8'(f - 8'h20);
    end
    return f;
  endfunction

  function automatic int unsigned active_len();
    return (pattern_len > PAT_BYTES) ? PAT_BYTES : int'(pattern_len);
  endfunction

  function automatic out_req_t match_step(input in_req_t r);
    out_req_t    o;
    int unsigned n;
    logic        hit;
    o = '0;
    n = active_len();
    if (r.end_of_line) begin
      if (line_hit) begin
        o.line_had_match = 1'b1;
        if (lines_total != COUNT_MAX) lines_total++;
      end
      line_hit = 1'b0;
      fill_count = 0;
    end else begin
      o.lowered_char = to_lower(r.char_code);
      window = {window[PAT_BYTES-2:0], o.lowered_char};
      if (fill_count < PAT_BYTES) fill_count++;
      if (n > 0 && fill_count >= n) begin
        hit = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (window[n-1-i] != to_lower(pattern_regs[i])) hit = 1'b0;
        end
        if (hit) begin
          o.match_end = 1'b1;
          if (match_total != COUNT_MAX) match_total++;
          line_hit = 1'b1;
          fill_count = 0;
        end
      end
    end
    o.total_matches = match_total;
    o.matching_lines = lines_total;
    return o;
  endfunction

  function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] value);
    row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic row_t req_row(input logic eol, input logic [7:0] c,
                                   input logic fixed = 1'b0, input logic [7:0] lc = '0,
                                   input logic me = 1'b0, input logic lh = 1'b0,
                                   input logic [COUNT_W-1:0] tm = '0,
                                   input logic [COUNT_W-1:0] ml = '0);
    row_t r;
    r = '0;
    r.kind = ROW_REQ;
    r.req.char_code = c;
    r.req.end_of_line = eol;
    r.fixed = fixed;
    r.want.lowered_char = lc;
    r.want.match_end = me;
    r.want.line_had_match = lh;
    r.want.total_matches = tm;
    r.want.matching_lines = ml;
    return r;
  endfunction

  task automatic send_item(input in_req_t r, input logic fixed = 1'b0,
                           input out_req_t want = '0);
    out_req_t predicted;
    cfg_write <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // advance the predictor even where the expected result is typed in
    predicted = match_step(r);
    awaited_results.push_back(fixed ? want : predicted);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_PATTERN_LOW:  pattern_regs[7:0] = value;
      REG_PATTERN_HIGH: pattern_regs[15:8] = value;
      REG_PATTERN_LEN:  pattern_len = value[PAT_LEN_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    out_req_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding: %h", out_data);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.lowered_char !== want.lowered_char) begin
          $error("lowered_char: expected %h, actual %h", want.lowered_char,
                 out_data.lowered_char);
          errors++;
        end
        if (out_data.match_end !== want.match_end) begin
          $error("match_end: expected %b, actual %b", want.match_end, out_data.match_end);
          errors++;
        end
        if (out_data.line_had_match !== want.line_had_match) begin
          $error("line_had_match: expected %b, actual %b", want.line_had_match,
                 out_data.line_had_match);
          errors++;
        end
        if (out_data.total_matches !== want.total_matches) begin
          $error("total_matches: expected %0d, actual %0d", want.total_matches,
                 out_data.total_matches);
          errors++;
        end
        if (out_data.matching_lines !== want.matching_lines) begin
          $error("matching_lines: expected %0d, actual %0d", want.matching_lines,
                 out_data.matching_lines);
          errors++;
        end
      end
    end
  end

  initial begin
    #400us;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int                        idle_by_phase [4];
    int                        stall_by_phase [4];
    int                        sent;
    int                        pick;
    int                        n;
    int                        bad;
    logic                      mid_done;
    logic [7:0]                c;
    logic [PAT_BYTES-1:0][7:0] p;
    in_req_t                   r;

    idle_by_phase = '{0, 60, 0, 29};
    stall_by_phase = '{0, 0, 60, 29};

    directed_rows = '{
      // reset pattern is one zero byte
      req_row(1'b0, 8'h41, 1'b1, 8'h61, 1'b0, 1'b0, 0, 0),
      req_row(1'b0, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 1, 0),
      req_row(1'b1, 8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 1, 1),
      req_row(1'b1, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1, 1),
      // fold boundaries
      req_row(1'b0, 8'h40, 1'b1, 8'h40, 1'b0, 1'b0, 1, 1),
      req_row(1'b0, 8'h5B, 1'b1, 8'h5B, 1'b0, 1'b0, 1, 1),
      req_row(1'b0, 8'h5A, 1'b1, 8'h7A, 1'b0, 1'b0, 1, 1),
      req_row(1'b0, 8'hFF, 1'b1, 8'hFF, 1'b0, 1'b0, 1, 1),
      // char code dropped on end of line
      req_row(1'b1, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, 1, 1),
      reg_row(REG_PATTERN_LOW, 64'h0000_0000_0061_4261),
      reg_row(REG_PATTERN_LEN, 64'd3),
      reg_row(REG_UNUSED, '1),
      // non-overlapping: only the first of two overlapping matches counts
      req_row(1'b0, 8'h41), req_row(1'b0, 8'h42), req_row(1'b0, 8'h41),
      req_row(1'b0, 8'h42), req_row(1'b0, 8'h41), req_row(1'b1, 8'h00),
      // no match across a line break
      req_row(1'b0, 8'h61), req_row(1'b0, 8'h62), req_row(1'b1, 8'h00),
      req_row(1'b0, 8'h61),
      // length zero set mid-line: nothing matches
      reg_row(REG_PATTERN_LEN, 64'd0),
      req_row(1'b0, 8'h62), req_row(1'b0, 8'h61), req_row(1'b1, 8'h00)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_WRITE) begin
        write_reg(directed_rows[k].idx, directed_rows[k].value);
      end else begin
        send_item(directed_rows[k].req, directed_rows[k].fixed, directed_rows[k].want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      // bias the pattern towards a small alphabet so partial matches overlap
      for (int i = 0; i < PAT_BYTES; i++) begin
        pick = $urandom_range(9);
        if (pick < 5) p[i] = mixed_case(8'(8'h61 + $urandom_range(1)));
        else if (pick < 8) p[i] = mixed_case(8'(8'h61 + $urandom_range(25)));
        else p[i] = 8'($urandom_range(255));
      end
      write_reg(REG_PATTERN_LOW, p[7:0]);
      write_reg(REG_PATTERN_HIGH, p[15:8]);
      case (ph)
        0: write_reg(REG_PATTERN_LEN, 64'd1);
        1: write_reg(REG_PATTERN_LEN, 64'd31);
        2: write_reg(REG_PATTERN_LEN, 64'd16);
        default: write_reg(REG_PATTERN_LEN, 64'($urandom_range(2, 15)));
      endcase
      sent = 0;
      mid_done = 1'b0;
      while (sent < 100) begin
        if (!mid_done && sent >= 50) begin
          // hold requests until every result is back, then change length mid-line
          write_reg(REG_PATTERN_LEN, 64'($urandom_range(31)));
          mid_done = 1'b1;
        end
        pick = $urandom_range(99);
        n = active_len();
        r = '0;
        if (pick < 10) begin
          r.char_code = 8'($urandom_range(255));
          r.end_of_line = 1'b1;
          send_item(r);
          sent++;
        end else if (pick < 45 && n > 0) begin
          // whole pattern in random case, now and then with one byte broken
          bad = ($urandom_range(3) == 0) ? $urandom_range(n - 1) : -1;
          for (int i = 0; i < n; i++) begin
            c = mixed_case(pattern_regs[i]);
            if (i == bad) c = 8'($urandom_range(255));
            r.char_code = c;
            send_item(r);
            sent++;
          end
        end else if (pick < 80) begin
          r.char_code = mixed_case(pattern_regs[$urandom_range((n == 0) ? 15 : n - 1)]);
          send_item(r);
          sent++;
        end else begin
          r.char_code = 8'($urandom_range(255));
          send_item(r);
          sent++;
        end
      end
    end

    idle_pct = 0;
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
